>>> hw/rtl/mfm_pkg.sv
// ----------------------------------------------------------------------------
// mfm_pkg
// Shared types and codes of the message freshness monitor: command, status
// and state codes, the table entry, the result and the write request.
// ----------------------------------------------------------------------------
package mfm_pkg;

	localparam int NUM_MSGS_DEF = 16;
	localparam int ID_W         = 4;
	localparam int TIME_W       = 32;
	localparam int CMD_W        = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_RX       = 3'd0,
		CMD_TX       = 3'd1,
		CMD_QSTATE   = 3'd2,
		CMD_QHEALTH  = 3'd3,
		CMD_CHECKALL = 3'd4,
		CMD_LOAD     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_DIRMIS  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MS_UNSEEN = 2'd0,
		MS_FRESH  = 2'd1,
		MS_STALE  = 2'd2
	} mstate_t;

	localparam logic DIR_RX = 1'b0;
	localparam logic DIR_TX = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_LOOK  = 3'd1,
		S_SCAN  = 3'd2,
		S_SDONE = 3'd3,
		S_EXEC  = 3'd4
	} fsm_t;

	// One message as read back from the table.
	typedef struct packed {
		logic              defined;
		logic              seen;
		logic              direction;
		logic              mandatory;
		logic [TIME_W-1:0] timeout;
		logic [TIME_W-1:0] last_time;
	} entry_t;

	// Write request into the table.
	typedef struct packed {
		logic              desc_we;
		logic              time_we;
		logic              defined;
		logic              direction;
		logic              mandatory;
		logic [TIME_W-1:0] timeout;
		logic [TIME_W-1:0] now;
	} wr_t;

	typedef struct packed {
		status_t status;
		mstate_t msg_state;
		logic    healthy;
		logic    seen;
	} result_t;

	typedef struct packed {
		result_t res;
		logic    ev_ok;
		logic    load_ok;
		logic    elem_ok;
	} judge_t;

endpackage

>>> hw/rtl/mfm_table.sv
// ----------------------------------------------------------------------------
// mfm_table
// Message table: descriptor and timestamp memories with a registered read
// port, plus defined and seen flags that reset clears.
// ----------------------------------------------------------------------------
module mfm_table #(
	parameter int NUM_MSGS = mfm_pkg::NUM_MSGS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(NUM_MSGS)-1:0] rd_idx,
	output mfm_pkg::entry_t             rd_entry,
	input  logic [$clog2(NUM_MSGS)-1:0] wr_idx,
	input  mfm_pkg::wr_t                wr
);
	import mfm_pkg::*;

	localparam int DESC_W = TIME_W + 2;

	logic [DESC_W-1:0] desc_mem [NUM_MSGS];
	logic [TIME_W-1:0] time_mem [NUM_MSGS];
	logic [NUM_MSGS-1:0] def_q;
	logic [NUM_MSGS-1:0] seen_q;

	logic [DESC_W-1:0] desc_s1;
	logic [TIME_W-1:0] time_s1;
	logic              def_s1;
	logic              seen_s1;

	always_ff @(posedge clk) begin
		if (wr.desc_we) begin
			desc_mem[wr_idx] <= {wr.direction, wr.mandatory, wr.timeout};
		end
		if (wr.time_we) begin
			time_mem[wr_idx] <= wr.now;
		end
		desc_s1 <= desc_mem[rd_idx];
		time_s1 <= time_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_q   <= '0;
			seen_q  <= '0;
			def_s1  <= 1'b0;
			seen_s1 <= 1'b0;
		end else begin
			if (wr.desc_we) begin
				def_q[wr_idx] <= wr.defined;
			end
			if (wr.time_we) begin
				seen_q[wr_idx] <= 1'b1;
			end
			def_s1  <= def_q[rd_idx];
			seen_s1 <= seen_q[rd_idx];
		end
	end

	always_comb begin
		rd_entry.defined   = def_s1;
		rd_entry.seen      = seen_s1;
		rd_entry.direction = desc_s1[DESC_W-1];
		rd_entry.mandatory = desc_s1[DESC_W-2];
		rd_entry.timeout   = desc_s1[TIME_W-1:0];
		rd_entry.last_time = time_s1;
	end

endmodule

>>> hw/rtl/mfm_judge.sv
// ----------------------------------------------------------------------------
// mfm_judge
// Command evaluation: id and direction checks, wrap-safe freshness, health
// and the per-entry verdict used by the check-all scan.
// ----------------------------------------------------------------------------
module mfm_judge (
	input  mfm_pkg::cmd_t                cmd,
	input  logic                         id_valid,
	input  logic [mfm_pkg::TIME_W-1:0]   now,
	input  mfm_pkg::entry_t              ent,
	input  logic                         hl_acc,
	output mfm_pkg::judge_t              jdg
);
	import mfm_pkg::*;

	logic [TIME_W-1:0] elapsed;
	logic              fresh;
	logic              eligible;
	logic              want_dir;

	assign elapsed  = now - ent.last_time;
	assign fresh    = (ent.timeout == '0) || (elapsed <= ent.timeout);
	assign eligible = ent.defined && (ent.direction == DIR_RX) && ent.mandatory;
	assign want_dir = (cmd == CMD_TX) ? DIR_TX : DIR_RX;

	always_comb begin
		jdg               = '0;
		jdg.res.status    = ST_OK;
		jdg.res.msg_state = MS_UNSEEN;
		jdg.res.seen      = id_valid && ent.seen;
		jdg.elem_ok       = !eligible || (ent.seen && fresh);
		unique case (cmd)
			CMD_RX, CMD_TX: begin
				if (!id_valid || !ent.defined) begin
					jdg.res.status = ST_INVALID;
				end else if (ent.direction != want_dir) begin
					jdg.res.status = ST_DIRMIS;
				end else begin
					jdg.ev_ok    = 1'b1;
					jdg.res.seen = 1'b1;
				end
			end
			CMD_QSTATE: begin
				if (!id_valid || !ent.defined) begin
					jdg.res.status = ST_INVALID;
				end else if (ent.seen) begin
					jdg.res.msg_state = fresh ? MS_FRESH : MS_STALE;
				end
			end
			CMD_QHEALTH: begin
				if (!id_valid || !ent.defined) begin
					jdg.res.status = ST_INVALID;
				end else begin
					jdg.res.healthy = eligible && ent.seen && fresh;
				end
			end
			CMD_CHECKALL: begin
				jdg.res.healthy = hl_acc;
			end
			CMD_LOAD: begin
				if (!id_valid) begin
					jdg.res.status = ST_INVALID;
				end else begin
					jdg.load_ok = 1'b1;
				end
			end
			default: begin
				// unused command codes: report the seen mark only
			end
		endcase
	end

endmodule

>>> hw/rtl/message_freshness_monitor.sv
// ----------------------------------------------------------------------------
// message_freshness_monitor
// Per-message freshness monitor over a descriptor and timestamp table.
// ----------------------------------------------------------------------------
// One item goes in on the slave side, one result item comes out on the
// master side for each. Events, queries and loads pass through accept, then
// table read, then evaluate and write back; check-all walks ids 1 to
// NUM_MSGS-1 through the single table read port, one id a cycle. A result
// waits in the output register while the next item is accepted; the block
// stalls only when a new result is ready and the old one has not been
// taken. The defined and seen flags clear at reset, so the table is usable
// right after reset without a clearing pass.
// ----------------------------------------------------------------------------
module message_freshness_monitor #(
	parameter int NUM_MSGS = mfm_pkg::NUM_MSGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// msg_id[3:0], now_ms[35:4], desc_defined[36], desc_direction[37],
	// desc_mandatory[38], desc_timeout[70:39], zero pad[71]
	input  logic [71:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], msg_state[3:2], healthy[4], seen[5], zero pad[7:6]
	output logic [7:0]  m_tdata
);
	import mfm_pkg::*;

	localparam int IW = $clog2(NUM_MSGS);
	localparam logic [IW-1:0] SCAN_FIRST = IW'(1);
	localparam logic [IW-1:0] SCAN_LAST  = IW'(NUM_MSGS - 1);

	fsm_t state_q, state_d;

	// captured item
	logic [CMD_W-1:0]  cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic              def_q;
	logic              dir_q;
	logic              mand_q;
	logic [TIME_W-1:0] tmo_q;

	logic [IW-1:0]     scan_idx_q;
	logic              live_s1;
	logic              hl_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic              accept;
	logic              out_free;
	logic              fire;
	logic              id_valid;
	logic [IW+ID_W-1:0] id_wide;
	logic [IW-1:0]     id_idx;
	logic [IW-1:0]     rd_idx;
	entry_t            entry;
	wr_t               wr;
	judge_t            jdg;

	assign id_wide  = {{IW{1'b0}}, id_q};
	assign id_idx   = id_wide[IW-1:0];
	assign id_valid = (id_q != '0) && (32'(id_q) < 32'(NUM_MSGS));
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = (cmd_t'(s_tuser) == CMD_CHECKALL) ? S_SCAN : S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_EXEC;
			end
			S_SCAN: begin
				if (scan_idx_q == SCAN_LAST) begin
					state_d = S_SDONE;
				end
			end
			S_SDONE: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		s_tready = (state_q == S_IDLE);
		accept   = s_tready && s_tvalid;
		fire     = (state_q == S_EXEC) && out_free;
		rd_idx   = (state_q == S_SCAN) ? scan_idx_q : id_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_idx_q <= SCAN_FIRST;
			live_s1    <= 1'b0;
			hl_q       <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// scan entry read this cycle gets judged next cycle
			live_s1 <= (state_q == S_SCAN);
			if (accept) begin
				scan_idx_q <= SCAN_FIRST;
				hl_q       <= 1'b1;
			end else begin
				if (state_q == S_SCAN) begin
					scan_idx_q <= scan_idx_q + IW'(1);
				end
				// drop to unhealthy on the first failing mandatory rx id
				if (live_s1 && !jdg.elem_ok) begin
					hl_q <= 1'b0;
				end
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the item's payload for the whole operation
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			id_q   <= s_tdata[3:0];
			now_q  <= s_tdata[35:4];
			def_q  <= s_tdata[36];
			dir_q  <= s_tdata[37];
			mand_q <= s_tdata[38];
			tmo_q  <= s_tdata[70:39];
		end
		if (fire) begin
			m_tdata_q <= {2'b00, jdg.res.seen, jdg.res.healthy,
				jdg.res.msg_state, jdg.res.status};
		end
	end

	// write back only when the result goes to the output register
	always_comb begin
		wr.desc_we   = fire && jdg.load_ok;
		wr.time_we   = fire && jdg.ev_ok;
		wr.defined   = def_q;
		wr.direction = dir_q;
		wr.mandatory = mand_q;
		wr.timeout   = tmo_q;
		wr.now       = now_q;
	end

	mfm_table #(
		.NUM_MSGS(NUM_MSGS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_entry(entry),
		.wr_idx  (id_idx),
		.wr      (wr)
	);

	mfm_judge u_judge (
		.cmd     (cmd_t'(cmd_q)),
		.id_valid(id_valid),
		.now     (now_q),
		.ent     (entry),
		.hl_acc  (hl_q),
		.jdg     (jdg)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> bench/message_freshness_monitor_test.sv
// ----------------------------------------------------------------------------
// message_freshness_monitor_test
// Self-checking bench for the message freshness monitor: a directed opening
// covers the corner cases, then random traffic of loads, events and queries
// with random backpressure on both sides is checked against a predictor that
// keeps its own descriptor table, seen marks and timestamps.
// ----------------------------------------------------------------------------
module message_freshness_monitor_test;
	import mfm_pkg::*;

	localparam int NUM_MSGS     = NUM_MSGS_DEF;
	localparam int RANDOM_ITEMS = 2000;
	// Longest correct gap between handshakes is a check-all scan plus a long
	// receiver stall; this is many times that.
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = NUM_MSGS + 8;

	// Command codes the block must treat as no-ops.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	// One command item as it goes onto the slave side.
	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  msg_id;
		logic [31:0] now_ms;
		logic        defined;
		logic        direction;
		logic        mandatory;
		logic [31:0] timeout;
	} frame_cmd_t;

	// Descriptor as the predictor keeps it.
	typedef struct packed {
		logic        defined;
		logic        direction;
		logic        mandatory;
		logic [31:0] timeout;
	} desc_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// msg_id[3:0], now_ms[35:4], desc_defined[36], desc_direction[37],
	// desc_mandatory[38], desc_timeout[70:39], zero pad[71]
	logic [71:0] s_tdata = '0;
	// cmd[2:0]
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[1:0], msg_state[3:2], healthy[4], seen[5], zero pad[7:6]
	logic [7:0]  m_tdata;

	frame_cmd_t  cmd_backlog[$];
	result_t     expected_replies[$];
	int          planned_items = 1;
	int          n_accepted = 0;
	int          n_replies = 0;
	bit          mismatch_seen = 1'b0;

	// Predictor state.
	logic        heard [NUM_MSGS];
	logic [31:0] last_heard [NUM_MSGS];
	desc_t       descs [NUM_MSGS];

	message_freshness_monitor #(
		.NUM_MSGS(NUM_MSGS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Age of a defined message: unseen, fresh or stale. Elapsed time wraps
	// modulo 2^32, a zero timeout never goes stale, and an elapsed time equal
	// to the timeout is still fresh.
	function automatic mstate_t age_state(int unsigned id, logic [31:0] now);
		logic [31:0] elapsed;
		elapsed = now - last_heard[id];
		if (!heard[id])
			return MS_UNSEEN;
		if (descs[id].timeout == 32'd0 || elapsed <= descs[id].timeout)
			return MS_FRESH;
		return MS_STALE;
	endfunction

	// Only a defined, mandatory rx message that is fresh counts as healthy.
	function automatic logic is_healthy(int unsigned id, logic [31:0] now);
		return descs[id].defined && descs[id].direction == DIR_RX &&
			descs[id].mandatory && age_state(id, now) == MS_FRESH;
	endfunction

	// Work out the reply to one command and advance the predicted table.
	function automatic result_t track_message(frame_cmd_t c);
		result_t     r;
		int unsigned id;
		logic        id_valid;
		id = 32'(c.msg_id);
		id_valid = (id != 0) && (id < NUM_MSGS);
		r.status = ST_OK;
		r.msg_state = MS_UNSEEN;
		r.healthy = 1'b0;
		r.seen = 1'b0;
		case (c.cmd)
			CMD_RX, CMD_TX: begin
				if (!id_valid || !descs[id].defined)
					r.status = ST_INVALID;
				else if (descs[id].direction != ((c.cmd == CMD_TX) ? DIR_TX : DIR_RX))
					r.status = ST_DIRMIS;
				else begin
					heard[id] = 1'b1;
					last_heard[id] = c.now_ms;
				end
			end
			CMD_QSTATE: begin
				if (!id_valid || !descs[id].defined)
					r.status = ST_INVALID;
				else
					r.msg_state = age_state(id, c.now_ms);
			end
			CMD_QHEALTH: begin
				if (!id_valid || !descs[id].defined)
					r.status = ST_INVALID;
				else
					r.healthy = is_healthy(id, c.now_ms);
			end
			CMD_CHECKALL: begin
				// Undefined ids are skipped; an empty set of mandatory rx
				// messages counts as healthy.
				r.healthy = 1'b1;
				for (int i = 1; i < NUM_MSGS; i++) begin
					if (descs[i].defined && descs[i].direction == DIR_RX &&
							descs[i].mandatory && !is_healthy(i, c.now_ms))
						r.healthy = 1'b0;
				end
			end
			CMD_LOAD: begin
				// Replace the descriptor, keep the seen mark and timestamp.
				if (!id_valid)
					r.status = ST_INVALID;
				else
					descs[id] = '{c.defined, c.direction, c.mandatory, c.timeout};
			end
			default: begin
			end
		endcase
		if (id_valid)
			r.seen = heard[id];
		return r;
	endfunction

	// Idle share in percent for one side, by how far the run has come: the
	// sender idles lightly and the receiver heavily, then the other way
	// round, then neither idles.
	function automatic int idle_pct(int done, bit sender);
		int phase;
		phase = done * 3 / planned_items;
		case (phase)
			0:       return sender ? 7 : 82;
			1:       return sender ? 82 : 7;
			default: return 0;
		endcase
	endfunction

	function automatic frame_cmd_t make_cmd(logic [2:0] cmd, logic [3:0] id,
			logic [31:0] now);
		frame_cmd_t c;
		c.cmd = cmd;
		c.msg_id = id;
		c.now_ms = now;
		// Descriptor fields matter only if the code is a load; fill them with noise.
		c.defined = 1'($urandom_range(0, 1));
		c.direction = 1'($urandom_range(0, 1));
		c.mandatory = 1'($urandom_range(0, 1));
		c.timeout = $urandom;
		return c;
	endfunction

	function automatic frame_cmd_t make_load(logic [3:0] id, logic def, logic dir,
			logic man, logic [31:0] tmo);
		frame_cmd_t c;
		c.cmd = CMD_LOAD;
		c.msg_id = id;
		c.now_ms = $urandom;
		c.defined = def;
		c.direction = dir;
		c.mandatory = man;
		c.timeout = tmo;
		return c;
	endfunction

	// Driver: present the oldest pending item, hold it until accepted, and
	// record the expected reply at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			for (int i = 0; i < NUM_MSGS; i++) begin
				heard[i] = 1'b0;
				last_heard[i] = 32'd0;
				descs[i] = '0;
			end
		end else begin
			if (s_tvalid && s_tready) begin
				expected_replies.push_back(track_message(cmd_backlog[0]));
				void'(cmd_backlog.pop_front());
				n_accepted++;
			end
			if (s_tvalid && !s_tready) begin
				// hold the item until the block takes it
			end else if (cmd_backlog.size() != 0 &&
					$urandom_range(0, 99) >= idle_pct(n_accepted, 1'b1)) begin
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, cmd_backlog[0].timeout, cmd_backlog[0].mandatory,
					cmd_backlog[0].direction, cmd_backlog[0].defined,
					cmd_backlog[0].now_ms, cmd_backlog[0].msg_id};
				s_tuser <= cmd_backlog[0].cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: compare each reply with the oldest expectation, then pick
	// the next ready level.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_replies++;
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with none expected, got %h", $time, m_tdata);
					mismatch_seen = 1'b1;
				end else begin
					want = expected_replies.pop_front();
					if (m_tdata[1:0] != want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, m_tdata[1:0]);
						mismatch_seen = 1'b1;
					end
					if (m_tdata[3:2] != want.msg_state) begin
						$display("%0t: msg_state expected %0d got %0d",
							$time, want.msg_state, m_tdata[3:2]);
						mismatch_seen = 1'b1;
					end
					if (m_tdata[4] != want.healthy) begin
						$display("%0t: healthy expected %0d got %0d",
							$time, want.healthy, m_tdata[4]);
						mismatch_seen = 1'b1;
					end
					if (m_tdata[5] != want.seen) begin
						$display("%0t: seen expected %0d got %0d",
							$time, want.seen, m_tdata[5]);
						mismatch_seen = 1'b1;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= idle_pct(n_replies, 1'b0));
		end
	end

	// Watchdog: end the run once nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		frame_cmd_t  c;
		logic [31:0] t_ms;
		logic        gen_dir [NUM_MSGS];
		int          pick;
		int          id;

		// Directed opening: invalid ids, undefined entries, direction
		// mismatch, the fresh/stale boundary across the time wrap, a zero
		// timeout, the largest timeout, check-all on an empty table and
		// with an unseen mandatory message, spare codes, and a reload that
		// undefines an entry but keeps its seen mark.
		cmd_backlog.push_back(make_cmd(CMD_QSTATE, 4'd0, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_RX, 4'd3, 32'h10));
		cmd_backlog.push_back(make_cmd(CMD_CHECKALL, 4'd0, 32'hFFFF_FFFF));
		cmd_backlog.push_back(make_load(4'd0, 1'b1, DIR_TX, 1'b1, 32'hFFFF_FFFF));
		cmd_backlog.push_back(make_load(4'd1, 1'b1, DIR_RX, 1'b1, 32'd100));
		cmd_backlog.push_back(make_load(4'd15, 1'b1, DIR_TX, 1'b0, 32'hFFFF_FFFF));
		cmd_backlog.push_back(make_load(4'd2, 1'b1, DIR_RX, 1'b1, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_QSTATE, 4'd1, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_QHEALTH, 4'd1, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_CHECKALL, 4'd5, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_TX, 4'd1, 32'd5));
		cmd_backlog.push_back(make_cmd(CMD_RX, 4'd1, 32'hFFFF_FFF0));
		cmd_backlog.push_back(make_cmd(CMD_RX, 4'd15, 32'd7));
		cmd_backlog.push_back(make_cmd(CMD_TX, 4'd15, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_QSTATE, 4'd1, 32'h54));
		cmd_backlog.push_back(make_cmd(CMD_QSTATE, 4'd1, 32'h55));
		cmd_backlog.push_back(make_cmd(CMD_RX, 4'd2, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_QHEALTH, 4'd2, 32'h8000_0000));
		cmd_backlog.push_back(make_cmd(CMD_QHEALTH, 4'd15, 32'd1));
		cmd_backlog.push_back(make_cmd(CMD_CHECKALL, 4'd0, 32'h54));
		cmd_backlog.push_back(make_cmd(CMD_QSTATE, 4'd15, 32'hFFFF_FFFF));
		cmd_backlog.push_back(make_cmd(CMD_SPARE_A, 4'd1, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_SPARE_B, 4'd0, 32'd0));
		cmd_backlog.push_back(make_load(4'd1, 1'b0, DIR_TX, 1'b0, 32'd0));
		cmd_backlog.push_back(make_cmd(CMD_QHEALTH, 4'd1, 32'h54));

		// Random part: start just below the wrap so the running clock
		// crosses it. Load every id first, then mostly well-formed traffic
		// with a slow clock so both fresh and stale answers show up.
		t_ms = 32'hFFFF_F000 + $urandom_range(0, 255);
		for (int i = 0; i < NUM_MSGS; i++)
			gen_dir[i] = DIR_RX;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			id = $urandom_range(1, NUM_MSGS - 1);
			if (n < NUM_MSGS - 1 || pick < 10) begin
				if (n < NUM_MSGS - 1)
					id = n + 1;
				c = make_load(4'(id), $urandom_range(0, 9) != 0,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(1, 300));
				case ($urandom_range(0, 6))
					0: c.timeout = 32'd0;
					1: c.timeout = $urandom;
					default: begin
					end
				endcase
			end else if (pick < 45) begin
				// event in the direction the table expects
				c = make_cmd((gen_dir[id] == DIR_TX) ? CMD_TX : CMD_RX, 4'(id), t_ms);
			end else if (pick < 65) begin
				c = make_cmd(CMD_QSTATE, 4'(id), t_ms);
			end else if (pick < 80) begin
				c = make_cmd(CMD_QHEALTH, 4'(id), t_ms);
			end else if (pick < 88) begin
				c = make_cmd(CMD_CHECKALL, 4'($urandom_range(0, 15)), t_ms);
			end else begin
				// noise: any code, any id, any time
				c = make_cmd(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
					$urandom);
			end
			if (c.cmd == CMD_LOAD && c.msg_id != 4'd0)
				gen_dir[c.msg_id] = c.direction;
			cmd_backlog.push_back(c);
			t_ms = t_ms + $urandom_range(0, 8);
		end
		planned_items = cmd_backlog.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every item to go in and every reply to come back, then
		// give the block time to show any stray reply.
		while (cmd_backlog.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!mismatch_seen && expected_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/mfm_pkg.sv
hw/rtl/mfm_table.sv
hw/rtl/mfm_judge.sv
hw/rtl/message_freshness_monitor.sv
bench/message_freshness_monitor_test.sv
